>>> src/dahs_pkg.sv
// Shared types, codes and step helpers for the dual-axis homing and stall supervisor.
package dahs_pkg;

  localparam int unsigned MaxCmd = 6;
  localparam int unsigned CmdIdxW = $clog2(MaxCmd);

  // Operation codes of an input item.
  localparam logic [2:0] MODE_TICK = 3'd0;
  localparam logic [2:0] MODE_MOVE = 3'd1;
  localparam logic [2:0] MODE_REF  = 3'd2;
  localparam logic [2:0] MODE_STOP = 3'd3;
  localparam logic [2:0] MODE_EN   = 3'd4;
  localparam logic [2:0] MODE_DIS  = 3'd5;

  // Command kinds.
  localparam logic [3:0] CMD_NONE      = 4'd0;
  localparam logic [3:0] CMD_MOVE      = 4'd1;
  localparam logic [3:0] CMD_NUDGE     = 4'd2;
  localparam logic [3:0] CMD_HOME_CW   = 4'd3;
  localparam logic [3:0] CMD_HOME_CCW  = 4'd4;
  localparam logic [3:0] CMD_BRAKE     = 4'd5;
  localparam logic [3:0] CMD_HOME_BOTH = 4'd6;
  localparam logic [3:0] CMD_STOP      = 4'd7;
  localparam logic [3:0] CMD_STOP_OFF  = 4'd8;
  localparam logic [3:0] CMD_ON        = 4'd9;

  // Homing phases.
  localparam logic [2:0] HP_IDLE    = 3'd0;
  localparam logic [2:0] HP_LEFT    = 3'd1;
  localparam logic [2:0] HP_RIGHT   = 3'd2;
  localparam logic [2:0] HP_BOTH    = 3'd3;
  localparam logic [2:0] HP_BACKOFF = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] CFG_SWAP    = 3'd0;
  localparam logic [2:0] CFG_ANGLE   = 3'd1;
  localparam logic [2:0] CFG_CURRENT = 3'd2;
  localparam logic [2:0] CFG_TIMEOUT = 3'd3;
  localparam logic [2:0] CFG_DRIFT   = 3'd4;
  localparam logic [2:0] CFG_SETTLE  = 3'd5;
  localparam logic [2:0] CFG_STALL   = 3'd6;

  // Status flag bits.
  localparam int ST_EN    = 0;
  localparam int ST_CAL   = 1;
  localparam int ST_CL    = 2;
  localparam int ST_CR    = 3;
  localparam int ST_STALL = 4;

  // Arm status after reset: enabled only.
  localparam logic [4:0] ArmRst = 5'b00001;

  // Homing flag bits.
  localparam int HF_BRK_L  = 0;
  localparam int HF_BRK_R  = 1;
  localparam int HF_DONE_L = 2;
  localparam int HF_DONE_R = 3;
  localparam int HF_SEQ    = 4;

  localparam logic [1:0] MP_IDLE = 2'd0;
  localparam logic [1:0] MP_ACK  = 2'd1;
  localparam logic [1:0] MP_MOVE = 2'd2;

  localparam logic [15:0] CtrlSelA     = 16'h0010;
  localparam logic [15:0] CtrlSelB     = 16'h0020;
  localparam logic [15:0] NudgeTicks   = 16'd10;
  localparam logic [7:0]  NudgeSpeed   = 8'd20;
  localparam logic [31:0] NudgeGapMs   = 32'd200;
  localparam logic [3:0]  RefOk        = 4'd1;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [15:0] pos_a;
    logic signed [15:0] pos_b;
    logic signed [15:0] aux_a;
    logic signed [15:0] aux_b;
    logic [3:0]         ref_a;
    logic [3:0]         ref_b;
    logic               endstop_left;
    logic               endstop_right;
    logic [31:0]        now_ms;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         cmd_kind;
    logic [1:0]         cmd_channel;
    logic signed [15:0] cmd_pos_a;
    logic signed [15:0] cmd_pos_b;
    logic [7:0]         cmd_speed_a;
    logic [7:0]         cmd_speed_b;
    logic [1:0]         move_state;
    logic [4:0]         status_flags;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [3:0]         kind;
    logic [1:0]         ch;
    logic signed [15:0] pa;
    logic signed [15:0] pb;
    logic [7:0]         sa;
    logic [7:0]         sb;
  } cmd_t;

  typedef struct packed {
    logic        swap_ch;
    logic [14:0] angle_limit_ticks;
    logic [14:0] stall_current_ma;
    logic [19:0] homing_timeout_ms;
    logic [9:0]  stall_drift_ticks;
    logic [15:0] settle_ms;
    logic [15:0] stall_hold_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         move_phase;
    logic               settling;
    logic [31:0]        settle_start;
    logic signed [15:0] target_left;
    logic signed [15:0] target_right;
    logic               stall_armed;
    logic [31:0]        stall_start;
    logic signed [15:0] stall_pos_left;
    logic signed [15:0] stall_pos_right;
    logic [2:0]         homing_phase;
    logic [1:0]         pending_side;
    logic [3:0]         lref_l;
    logic [3:0]         lref_r;
    logic [4:0]         homing_flags;
    logic [31:0]        homing_start;
    logic [31:0]        nudge_time;
    logic               nudge_was_left;
    logic [4:0]         arm_status;
  } st_t;

  // Working set of one step: the state so far and the commands so far.
  typedef struct packed {
    st_t                     s;
    cmd_t [MaxCmd-1:0]       c;
    logic [2:0]              n;
  } wk_t;

  // What the result buffer holds for one item.
  typedef struct packed {
    cmd_t [MaxCmd-1:0] c;
    logic [2:0]        n;
    logic [1:0]        move_state;
    logic [4:0]        status;
  } res_t;

  function automatic cmd_t mk_cmd(logic [3:0] kind, logic [1:0] ch,
                                  logic signed [15:0] pa, logic signed [15:0] pb,
                                  logic [7:0] sa, logic [7:0] sb);
    cmd_t c;
    c.kind = kind;
    c.ch   = ch;
    c.pa   = pa;
    c.pb   = pb;
    c.sa   = sa;
    c.sb   = sb;
    return c;
  endfunction

  function automatic logic [1:0] ch_left(logic sw);
    return sw ? 2'd2 : 2'd1;
  endfunction

  function automatic logic [1:0] ch_right(logic sw);
    return sw ? 2'd1 : 2'd2;
  endfunction

  function automatic logic [16:0] absdiff(logic signed [15:0] a, logic signed [15:0] b);
    logic [16:0] d;
    d = {a[15], a} - {b[15], b};
    return d[16] ? (17'd0 - d) : d;
  endfunction

  function automatic logic [15:0] abs16(logic signed [15:0] a);
    return a[15] ? (16'd0 - a) : a;
  endfunction

  function automatic wk_t emit(wk_t w, cmd_t c);
    wk_t r;
    r = w;
    if (w.n < 3'(MaxCmd)) begin
      r.c[w.n[CmdIdxW-1:0]] = c;
      r.n = w.n + 3'd1;
    end
    return r;
  endfunction

  function automatic wk_t disable_arm(wk_t w);
    wk_t r;
    r = emit(w, mk_cmd(CMD_STOP_OFF, 2'd0, 16'sd0, 16'sd0, 8'd0, 8'd0));
    r.s.arm_status[ST_EN] = 1'b0;
    r.s.move_phase = MP_IDLE;
    return r;
  endfunction

  function automatic wk_t end_homing(wk_t w);
    wk_t r;
    r = w;
    r.s.homing_flags[HF_SEQ] = 1'b0;
    r.s.arm_status[ST_CAL] = 1'b0;
    r.s.homing_phase = HP_IDLE;
    return r;
  endfunction

  function automatic wk_t start_ref(wk_t w, logic [3:0] side, logic [31:0] now,
                                    logic endl, logic endr, logic sw);
    wk_t  r;
    logic want_l;
    logic want_r;
    r = w;
    want_l = ((side == 4'd0) || (side == 4'd2)) && endl;
    want_r = ((side == 4'd1) || (side == 4'd2)) && endr;
    if (r.s.arm_status[ST_EN] && (r.s.homing_phase == HP_IDLE) && (side <= 4'd2)) begin
      r.s.lref_l = 4'd0;
      r.s.lref_r = 4'd0;
      r.s.homing_flags[HF_BRK_L] = 1'b0;
      r.s.homing_flags[HF_BRK_R] = 1'b0;
      r.s.homing_start = now;
      r.s.move_phase = MP_IDLE;
      r.s.arm_status[ST_STALL] = 1'b0;
      r.s.stall_armed = 1'b0;
      r.s.arm_status[ST_CAL] = 1'b1;
      if (want_l || want_r) begin
        r.s.homing_phase = HP_BACKOFF;
        r.s.pending_side = side[1:0];
        r.s.nudge_time = 32'd0;
      end else if (side == 4'd0) begin
        r.s.homing_phase = HP_LEFT;
        r = emit(r, mk_cmd(CMD_HOME_CW, ch_left(sw), 16'sd0, 16'sd0, 8'd0, 8'd0));
      end else if (side == 4'd1) begin
        r.s.homing_phase = HP_RIGHT;
        r = emit(r, mk_cmd(CMD_HOME_CCW, ch_right(sw), 16'sd0, 16'sd0, 8'd0, 8'd0));
      end else begin
        r.s.arm_status[ST_CL] = 1'b0;
        r.s.arm_status[ST_CR] = 1'b0;
        r.s.homing_phase = HP_BOTH;
        r.s.homing_flags = {1'b1, 2'b00, r.s.homing_flags[HF_BRK_R], r.s.homing_flags[HF_BRK_L]};
        r = emit(r, mk_cmd(CMD_HOME_BOTH, 2'd0, sw ? CtrlSelB : CtrlSelA,
                           sw ? CtrlSelA : CtrlSelB, 8'd0, 8'd0));
      end
    end
    return r;
  endfunction

  function automatic wk_t chain_ref(wk_t w, logic [3:0] side, logic [31:0] now,
                                    logic endl, logic endr, logic sw);
    wk_t r;
    r = w;
    r.s.homing_phase = HP_IDLE;
    r = start_ref(r, side, now, endl, endr, sw);
    if (r.s.homing_phase == HP_IDLE) begin
      r = end_homing(r);
    end
    return r;
  endfunction

endpackage

>>> src/dahs_step.sv
// Combinational step: next state and commands for one registered input item.
module dahs_step (
  input  dahs_pkg::in_item_t item_i,
  input  dahs_pkg::cfg_t     cfg_i,
  input  dahs_pkg::st_t      st_i,
  output dahs_pkg::wk_t      wk_o
);

  dahs_pkg::wk_t      w;
  logic               sw;
  logic               endl;
  logic               endr;
  logic [31:0]        now;
  logic signed [15:0] cl;
  logic signed [15:0] cr;
  logic [3:0]         rl;
  logic [3:0]         rr;
  logic [15:0]        i1;
  logic [15:0]        i2;
  logic               in_tol;
  logic               need_l;
  logic               need_r;
  logic               nl;
  logic               nr;
  logic [1:0]         side_v;
  logic               ok_ref;
  logic signed [16:0] tl17;
  logic signed [16:0] tr17;
  logic signed [16:0] lim17;
  logic               move_ok;
  logic [7:0]         sl;
  logic [7:0]         sr;

  always_comb begin
    w      = '0;
    w.s    = st_i;
    sw     = cfg_i.swap_ch;
    endl   = item_i.endstop_left;
    endr   = item_i.endstop_right;
    now    = item_i.now_ms;
    cl     = sw ? item_i.pos_b : item_i.pos_a;
    cr     = sw ? item_i.pos_a : item_i.pos_b;
    rl     = sw ? item_i.ref_b : item_i.ref_a;
    rr     = sw ? item_i.ref_a : item_i.ref_b;
    i1     = dahs_pkg::abs16(item_i.aux_a);
    i2     = dahs_pkg::abs16(item_i.aux_b);
    in_tol = 1'b0;
    need_l = 1'b0;
    need_r = 1'b0;
    nl     = 1'b0;
    nr     = 1'b0;
    side_v = 2'd0;
    ok_ref = 1'b0;
    tl17   = {item_i.pos_a[15], item_i.pos_a};
    tr17   = {item_i.pos_b[15], item_i.pos_b};
    lim17  = {2'b00, cfg_i.angle_limit_ticks};
    sl     = item_i.aux_a[7:0];
    sr     = item_i.aux_b[7:0];
    move_ok = 1'b0;

    unique case (item_i.mode)
      dahs_pkg::MODE_TICK: begin
        // Move tracking: acknowledged, moving, settled.
        if (w.s.move_phase != dahs_pkg::MP_IDLE) begin
          in_tol = (dahs_pkg::absdiff(cl, w.s.target_left) <= 17'd1) &&
                   (dahs_pkg::absdiff(cr, w.s.target_right) <= 17'd1);
          if ((w.s.move_phase == dahs_pkg::MP_ACK) && !w.s.settling) begin
            w.s.settle_start = now;
            w.s.settling = 1'b1;
          end else if (in_tol) begin
            if (!w.s.settling) begin
              w.s.settle_start = now;
              w.s.settling = 1'b1;
            end else if ((now - w.s.settle_start) >= {16'd0, cfg_i.settle_ms}) begin
              w.s.move_phase = dahs_pkg::MP_IDLE;
              w.s.settling = 1'b0;
            end
          end else begin
            if (w.s.move_phase == dahs_pkg::MP_ACK) begin
              w.s.move_phase = dahs_pkg::MP_MOVE;
            end
            w.s.settling = 1'b0;
          end
        end

        // Stall guard: overcurrent while the position stays inside the drift window.
        if ((w.s.move_phase != dahs_pkg::MP_IDLE) && (w.s.homing_phase == dahs_pkg::HP_IDLE)) begin
          if ((i1 > {1'b0, cfg_i.stall_current_ma}) || (i2 > {1'b0, cfg_i.stall_current_ma})) begin
            if (!w.s.stall_armed) begin
              w.s.stall_start = now;
              w.s.stall_pos_left = cl;
              w.s.stall_pos_right = cr;
              w.s.stall_armed = 1'b1;
            end else if ((dahs_pkg::absdiff(cl, w.s.stall_pos_left) >
                          {7'd0, cfg_i.stall_drift_ticks}) ||
                         (dahs_pkg::absdiff(cr, w.s.stall_pos_right) >
                          {7'd0, cfg_i.stall_drift_ticks})) begin
              w.s.stall_start = now;
              w.s.stall_pos_left = cl;
              w.s.stall_pos_right = cr;
            end else if ((now - w.s.stall_start) >= {16'd0, cfg_i.stall_hold_ms}) begin
              w.s.arm_status[dahs_pkg::ST_STALL] = 1'b1;
              w.s.arm_status[dahs_pkg::ST_CL] = 1'b0;
              w.s.arm_status[dahs_pkg::ST_CR] = 1'b0;
              w.s.stall_armed = 1'b0;
              w = dahs_pkg::disable_arm(w);
            end
          end else begin
            w.s.stall_armed = 1'b0;
          end
        end

        if (rl != 4'd0) begin
          w.s.lref_l = rl;
        end
        if (rr != 4'd0) begin
          w.s.lref_r = rr;
        end

        if ((w.s.homing_phase != dahs_pkg::HP_IDLE) && (cfg_i.homing_timeout_ms != 20'd0) &&
            ((now - w.s.homing_start) > {12'd0, cfg_i.homing_timeout_ms})) begin
          w.s.arm_status[dahs_pkg::ST_CAL] = 1'b0;
          w.s.arm_status[dahs_pkg::ST_CL] = 1'b0;
          w.s.arm_status[dahs_pkg::ST_CR] = 1'b0;
          w.s.homing_phase = dahs_pkg::HP_IDLE;
          w.s.homing_flags[dahs_pkg::HF_SEQ] = 1'b0;
          w = dahs_pkg::disable_arm(w);
        end

        unique case (w.s.homing_phase)
          dahs_pkg::HP_LEFT: begin
            if (w.s.lref_l != 4'd0) begin
              ok_ref = (w.s.lref_l == dahs_pkg::RefOk);
              if (ok_ref) begin
                w.s.arm_status[dahs_pkg::ST_CL] = 1'b1;
              end
              if (w.s.homing_flags[dahs_pkg::HF_SEQ] && ok_ref) begin
                w = dahs_pkg::chain_ref(w, 4'd1, now, endl, endr, sw);
              end else begin
                w = dahs_pkg::end_homing(w);
              end
            end else if (endl && !w.s.homing_flags[dahs_pkg::HF_BRK_L]) begin
              w = dahs_pkg::emit(w, dahs_pkg::mk_cmd(dahs_pkg::CMD_BRAKE, dahs_pkg::ch_left(sw),
                                                    16'sd0, 16'sd0, 8'd0, 8'd0));
              w.s.homing_flags[dahs_pkg::HF_BRK_L] = 1'b1;
            end
          end
          dahs_pkg::HP_RIGHT: begin
            if (w.s.lref_r != 4'd0) begin
              if (w.s.lref_r == dahs_pkg::RefOk) begin
                w.s.arm_status[dahs_pkg::ST_CR] = 1'b1;
              end
              w = dahs_pkg::end_homing(w);
            end else if (endr && !w.s.homing_flags[dahs_pkg::HF_BRK_R]) begin
              w = dahs_pkg::emit(w, dahs_pkg::mk_cmd(dahs_pkg::CMD_BRAKE, dahs_pkg::ch_right(sw),
                                                    16'sd0, 16'sd0, 8'd0, 8'd0));
              w.s.homing_flags[dahs_pkg::HF_BRK_R] = 1'b1;
            end
          end
          dahs_pkg::HP_BOTH: begin
            if (!w.s.homing_flags[dahs_pkg::HF_DONE_L]) begin
              if (w.s.lref_l != 4'd0) begin
                w.s.homing_flags[dahs_pkg::HF_DONE_L] = 1'b1;
              end else if (endl && !w.s.homing_flags[dahs_pkg::HF_BRK_L]) begin
                w = dahs_pkg::emit(w, dahs_pkg::mk_cmd(dahs_pkg::CMD_BRAKE,
                                   dahs_pkg::ch_left(sw), 16'sd0, 16'sd0, 8'd0, 8'd0));
                w.s.homing_flags[dahs_pkg::HF_BRK_L] = 1'b1;
              end
            end
            if (!w.s.homing_flags[dahs_pkg::HF_DONE_R]) begin
              if (w.s.lref_r != 4'd0) begin
                w.s.homing_flags[dahs_pkg::HF_DONE_R] = 1'b1;
              end else if (endr && !w.s.homing_flags[dahs_pkg::HF_BRK_R]) begin
                w = dahs_pkg::emit(w, dahs_pkg::mk_cmd(dahs_pkg::CMD_BRAKE,
                                   dahs_pkg::ch_right(sw), 16'sd0, 16'sd0, 8'd0, 8'd0));
                w.s.homing_flags[dahs_pkg::HF_BRK_R] = 1'b1;
              end
            end
            if (w.s.homing_flags[dahs_pkg::HF_DONE_L] && w.s.homing_flags[dahs_pkg::HF_DONE_R]) begin
              ok_ref = (w.s.lref_l == dahs_pkg::RefOk) && (w.s.lref_r == dahs_pkg::RefOk);
              if (w.s.homing_flags[dahs_pkg::HF_SEQ] && ok_ref) begin
                w = dahs_pkg::chain_ref(w, 4'd0, now, endl, endr, sw);
              end else begin
                w = dahs_pkg::end_homing(w);
              end
            end
          end
          dahs_pkg::HP_BACKOFF: begin
            need_l = (w.s.pending_side == 2'd0) || (w.s.pending_side == 2'd2);
            need_r = (w.s.pending_side == 2'd1) || (w.s.pending_side == 2'd2);
            nl = need_l && endl;
            nr = need_r && endr;
            if (!nl && !nr) begin
              side_v = w.s.pending_side;
              w.s.pending_side = 2'd0;
              w.s.homing_phase = dahs_pkg::HP_IDLE;
              w.s.arm_status[dahs_pkg::ST_CAL] = 1'b0;
              w = dahs_pkg::start_ref(w, {2'b00, side_v}, now, endl, endr, sw);
            end else if ((now - w.s.nudge_time) >= dahs_pkg::NudgeGapMs) begin
              // Nudges alternate between sides while both endstops are held.
              if (nl && (!nr || !w.s.nudge_was_left)) begin
                w = dahs_pkg::emit(w, dahs_pkg::mk_cmd(dahs_pkg::CMD_NUDGE,
                                   dahs_pkg::ch_left(sw), cl - dahs_pkg::NudgeTicks, 16'sd0,
                                   dahs_pkg::NudgeSpeed, 8'd0));
                w.s.nudge_was_left = 1'b1;
              end else if (nr) begin
                w = dahs_pkg::emit(w, dahs_pkg::mk_cmd(dahs_pkg::CMD_NUDGE,
                                   dahs_pkg::ch_right(sw), cr + dahs_pkg::NudgeTicks, 16'sd0,
                                   dahs_pkg::NudgeSpeed, 8'd0));
                w.s.nudge_was_left = 1'b0;
              end
              w.s.nudge_time = now;
            end
          end
          default: begin
          end
        endcase
      end

      dahs_pkg::MODE_MOVE: begin
        move_ok = w.s.arm_status[dahs_pkg::ST_CL] && w.s.arm_status[dahs_pkg::ST_CR] &&
                  w.s.arm_status[dahs_pkg::ST_EN] &&
                  !(endl && (tl17 > 17'sd0)) && !(endr && (tr17 < 17'sd0)) &&
                  !((lim17 != 17'sd0) && ((tl17 > 17'sd0) || (tl17 < -lim17) ||
                                          (tr17 < 17'sd0) || (tr17 > lim17)));
        if (move_ok) begin
          w = dahs_pkg::emit(w, dahs_pkg::mk_cmd(dahs_pkg::CMD_MOVE, 2'd0,
                             sw ? item_i.pos_b : item_i.pos_a,
                             sw ? item_i.pos_a : item_i.pos_b,
                             sw ? sr : sl, sw ? sl : sr));
          w.s.target_left  = item_i.pos_a;
          w.s.target_right = item_i.pos_b;
          w.s.settling     = 1'b0;
          w.s.settle_start = 32'd0;
          w.s.stall_armed  = 1'b0;
          w.s.stall_start  = 32'd0;
          w.s.arm_status[dahs_pkg::ST_STALL] = 1'b0;
          w.s.move_phase   = dahs_pkg::MP_ACK;
        end
      end

      dahs_pkg::MODE_REF: begin
        w = dahs_pkg::start_ref(w, item_i.ref_a, now, endl, endr, sw);
      end

      dahs_pkg::MODE_STOP: begin
        if (w.s.homing_phase != dahs_pkg::HP_IDLE) begin
          w = dahs_pkg::end_homing(w);
        end
        w = dahs_pkg::emit(w, dahs_pkg::mk_cmd(dahs_pkg::CMD_STOP, 2'd0,
                                              16'sd0, 16'sd0, 8'd0, 8'd0));
        w.s.move_phase = dahs_pkg::MP_IDLE;
      end

      dahs_pkg::MODE_EN: begin
        w.s.arm_status[dahs_pkg::ST_EN] = 1'b1;
        w = dahs_pkg::emit(w, dahs_pkg::mk_cmd(dahs_pkg::CMD_ON, 2'd0,
                                              16'sd0, 16'sd0, 8'd0, 8'd0));
      end

      dahs_pkg::MODE_DIS: begin
        w = dahs_pkg::disable_arm(w);
      end

      default: begin
      end
    endcase

    // An item without a command still reports the status once.
    if (w.n == 3'd0) begin
      w = dahs_pkg::emit(w, dahs_pkg::mk_cmd(dahs_pkg::CMD_NONE, 2'd0,
                                            16'sd0, 16'sd0, 8'd0, 8'd0));
    end
  end

  assign wk_o = w;

endmodule

>>> src/dahs_outbuf.sv
// Result register that holds the commands of one item and hands them out one per transfer.
module dahs_outbuf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  dahs_pkg::res_t       res_i,
  output logic                 free_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output dahs_pkg::out_item_t  out_item_o
);

  logic                                bv_q;
  logic                                bv_d;
  logic [dahs_pkg::CmdIdxW-1:0]        idx_q;
  logic [dahs_pkg::CmdIdxW-1:0]        idx_d;
  dahs_pkg::res_t                      res_q;
  logic                                is_last;
  logic                                take;
  dahs_pkg::cmd_t                      cur;

  assign cur     = res_q.c[idx_q];
  assign is_last = ({1'b0, idx_q} + 4'd1) >= {1'b0, res_q.n};
  assign take    = bv_q && !out_stall_i;
  assign free_o  = !bv_q || (take && is_last);

  always_comb begin
    bv_d  = bv_q;
    idx_d = idx_q;
    if (load_i) begin
      bv_d  = 1'b1;
      idx_d = '0;
    end else if (take) begin
      if (is_last) begin
        bv_d = 1'b0;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bv_q  <= 1'b0;
      idx_q <= '0;
    end else begin
      bv_q  <= bv_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o              = bv_q;
  assign out_item_o.cmd_kind      = cur.kind;
  assign out_item_o.cmd_channel   = cur.ch;
  assign out_item_o.cmd_pos_a     = cur.pa;
  assign out_item_o.cmd_pos_b     = cur.pb;
  assign out_item_o.cmd_speed_a   = cur.sa;
  assign out_item_o.cmd_speed_b   = cur.sb;
  assign out_item_o.move_state    = res_q.move_state;
  assign out_item_o.status_flags  = res_q.status;
  assign out_item_o.last          = is_last;

endmodule

>>> src/dual_axis_homing_stall_supervisor_core.sv
// Top level of the dual-axis homing and stall supervisor.
//
// Input channel: in_valid_i / in_stall_o carry one operation per transfer (tick with
// motor feedback, move, reference, stop, enable, disable). Output channel:
// out_valid_o / out_stall_i carry the resulting motor commands, one per transfer, with
// the arm status after the operation; last marks the final command of an operation.
// An operation that causes no command still yields one result of kind none.
// Path: an accepted item is held in the input register, is evaluated in a single
// pass once the result register is free, and its results are presented from there.
// Throughput: one item per cycle while each item gives one result and the receiver does
// not stall; an item with n results (up to six) occupies the result register for n
// transfers, so the sustained rate is set by the number of results per item.
// A stalled receiver holds the current result; the input register keeps taking one item
// and then stalls the sender until the result register drains.
// Configuration writes are taken at any edge with cfg_we_i high and are meant for idle
// periods. Reset clears all channel state, the arm reports enabled only, and the
// registers take their documented defaults.
module dual_axis_homing_stall_supervisor_core #(
  parameter int unsigned TICKS_PER_REV = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  dahs_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dahs_pkg::out_item_t out_item_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [19:0]         cfg_wdata_i
);

  localparam int unsigned AngleRst = 60 * TICKS_PER_REV / 360;
  localparam int unsigned DriftRst = 24 * TICKS_PER_REV / 3600;

  dahs_pkg::cfg_t     cfg_q;
  dahs_pkg::cfg_t     cfg_d;
  dahs_pkg::st_t      st_q;
  dahs_pkg::in_item_t item_q;
  logic               iv_q;
  logic               iv_d;
  logic               fire;
  logic               in_take;
  logic               buf_free;
  dahs_pkg::wk_t      wk;
  dahs_pkg::res_t     res;

  assign fire       = iv_q && buf_free;
  assign in_stall_o = iv_q && !fire;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    iv_d = iv_q;
    if (in_take) begin
      iv_d = 1'b1;
    end else if (fire) begin
      iv_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q <= 1'b0;
    end else begin
      iv_q <= iv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q <= in_item_i;
    end
  end

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dahs_pkg::CFG_SWAP:    cfg_d.swap_ch           = cfg_wdata_i[0];
        dahs_pkg::CFG_ANGLE:   cfg_d.angle_limit_ticks = cfg_wdata_i[14:0];
        dahs_pkg::CFG_CURRENT: cfg_d.stall_current_ma  = cfg_wdata_i[14:0];
        dahs_pkg::CFG_TIMEOUT: cfg_d.homing_timeout_ms = cfg_wdata_i;
        dahs_pkg::CFG_DRIFT:   cfg_d.stall_drift_ticks = cfg_wdata_i[9:0];
        dahs_pkg::CFG_SETTLE:  cfg_d.settle_ms         = cfg_wdata_i[15:0];
        dahs_pkg::CFG_STALL:   cfg_d.stall_hold_ms     = cfg_wdata_i[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.swap_ch           <= 1'b0;
      cfg_q.angle_limit_ticks <= 15'(AngleRst);
      cfg_q.stall_current_ma  <= 15'd3000;
      cfg_q.homing_timeout_ms <= 20'd10000;
      cfg_q.stall_drift_ticks <= 10'(DriftRst);
      cfg_q.settle_ms         <= 16'd100;
      cfg_q.stall_hold_ms     <= 16'd200;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  dahs_step u_step (
    .item_i (item_q),
    .cfg_i  (cfg_q),
    .st_i   (st_q),
    .wk_o   (wk)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{arm_status: dahs_pkg::ArmRst, default: '0};
    end else if (fire) begin
      st_q <= wk.s;
    end
  end

  assign res.c          = wk.c;
  assign res.n          = wk.n;
  assign res.move_state = wk.s.move_phase;
  assign res.status     = wk.s.arm_status;

  dahs_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .res_i       (res),
    .free_o      (buf_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

`ifndef SYNTHESIS
  // Every evaluated item produces at least one result.
  a_fire_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |-> (wk.n != 3'd0))
    else $error("item evaluated without a result");

  // A result that is not the last of its item is followed by another one.
  a_more_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.last && !out_stall_i) |=> out_valid_o)
    else $error("result stream cut before last");

  // The sender is only stalled while the input register holds an item.
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> iv_q)
    else $error("input stalled with empty input register");

  // Move tracking never reaches an unused phase code.
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.move_phase != 2'd3)
    else $error("move phase out of range");
`endif

endmodule
